// ===== hw/rtl/lba_pkg.sv =====
// ============================================================================
// Linked block allocator package
// Types, operation codes, result status codes and configuration indexes
// that the allocator's modules share.
// ============================================================================
package lba_pkg;

    // Operation codes carried by an input item.
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_LINK = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_ALLOC = 3'd0;
    localparam logic [2:0] ST_PEND  = 3'd1;
    localparam logic [2:0] ST_DEL   = 3'd2;
    localparam logic [2:0] ST_IGN   = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;
    localparam logic [2:0] ST_LINK  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // File record states.
    localparam logic [1:0] FS_PENDING = 2'd0;
    localparam logic [1:0] FS_ALLOC   = 2'd1;
    localparam logic [1:0] FS_DELETED = 2'd2;

    // Configuration register indexes and reset values.
    localparam logic        CFG_BLOCK_BYTES   = 1'b0;
    localparam logic        CFG_BLOCKS_IN_USE = 1'b1;
    localparam logic [15:0] BB_RESET          = 16'd512;
    localparam logic [6:0]  BIU_RESET         = 7'd64;

    // Restoring divider: one quotient bit per step over a 25-bit dividend.
    localparam logic [4:0]  DIV_STEPS = 5'd25;

    // Datapath command codes.
    localparam logic [4:0] D_NOP    = 5'd0;
    localparam logic [4:0] D_CLR    = 5'd1;
    localparam logic [4:0] D_IDLE   = 5'd2;
    localparam logic [4:0] D_ADD    = 5'd3;
    localparam logic [4:0] D_LRD    = 5'd4;
    localparam logic [4:0] D_LEMIT  = 5'd5;
    localparam logic [4:0] D_DRD    = 5'd6;
    localparam logic [4:0] D_DBAD   = 5'd7;
    localparam logic [4:0] D_DSTART = 5'd8;
    localparam logic [4:0] D_WALK   = 5'd9;
    localparam logic [4:0] D_WNEXT  = 5'd10;
    localparam logic [4:0] D_DFIN   = 5'd11;
    localparam logic [4:0] D_PRD    = 5'd12;
    localparam logic [4:0] D_PSKIP  = 5'd13;
    localparam logic [4:0] D_DIVLD  = 5'd14;
    localparam logic [4:0] D_DIV    = 5'd15;
    localparam logic [4:0] D_SSTART = 5'd16;
    localparam logic [4:0] D_SRD    = 5'd17;
    localparam logic [4:0] D_SCHK   = 5'd18;
    localparam logic [4:0] D_PEMIT  = 5'd19;
    localparam logic [4:0] D_PDONE  = 5'd20;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [23:0] file_bytes;
        logic [4:0]  file_id;
        logic [5:0]  block_index;
    } t_in;

    typedef struct packed {
        logic [4:0] result_file;
        logic [5:0] start_block;
        logic [5:0] end_block;
        logic [6:0] chain_blocks;
        logic [2:0] status;
        logic [6:0] free_left;
        logic [5:0] link_value;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [4:0] op;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic       in_fire;
        logic [1:0] in_op;
        logic       out_free;
        logic       file_ok;
        logic       zero_chain;
        logic       walk_last;
        logic       pass_end;
        logic       rec_pending;
        logic       div_done;
        logic       fits;
        logic       need_zero;
        logic       scan_free;
        logic       scan_last;
        logic       cfg_fmt;
    } t_stat;

endpackage

// ===== hw/rtl/lba_ctrl.sv =====
// ============================================================================
// Linked block allocator controller
// State machine that sequences the datapath through clearing, adds, deletes,
// link reads and the retry pass.
// ============================================================================
module lba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lba_pkg::t_stat i_stat,
    output lba_pkg::t_cmd  o_cmd
);
    import lba_pkg::*;

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_ADD   = 5'd2;
    localparam logic [4:0] S_LRD   = 5'd3;
    localparam logic [4:0] S_LEMIT = 5'd4;
    localparam logic [4:0] S_DRD   = 5'd5;
    localparam logic [4:0] S_DCHK  = 5'd6;
    localparam logic [4:0] S_WALK  = 5'd7;
    localparam logic [4:0] S_WNEXT = 5'd8;
    localparam logic [4:0] S_DFIN  = 5'd9;
    localparam logic [4:0] S_PRD   = 5'd10;
    localparam logic [4:0] S_PCHK  = 5'd11;
    localparam logic [4:0] S_PDIV  = 5'd12;
    localparam logic [4:0] S_PFIT  = 5'd13;
    localparam logic [4:0] S_SRD   = 5'd14;
    localparam logic [4:0] S_SCHK  = 5'd15;
    localparam logic [4:0] S_PEMIT = 5'd16;
    localparam logic [4:0] S_PDONE = 5'd17;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = D_NOP;
        o_cmd.emit  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = D_CLR;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.op = D_IDLE;
                if (i_stat.in_fire) begin
                    case (i_stat.in_op)
                        OP_ADD:  n_state = S_ADD;
                        OP_DEL:  n_state = S_DRD;
                        OP_LINK: n_state = S_LRD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                o_cmd.op   = D_ADD;
                o_cmd.emit = 1'b1;
                if (i_stat.out_free) n_state = S_PRD;
            end
            S_LRD: begin
                o_cmd.op = D_LRD;
                n_state  = S_LEMIT;
            end
            S_LEMIT: begin
                o_cmd.op   = D_LEMIT;
                o_cmd.emit = 1'b1;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_DRD: begin
                o_cmd.op = D_DRD;
                n_state  = S_DCHK;
            end
            S_DCHK: begin
                if (!i_stat.file_ok) begin
                    o_cmd.op   = D_DBAD;
                    o_cmd.emit = 1'b1;
                    if (i_stat.out_free) n_state = S_PRD;
                end else begin
                    o_cmd.op = D_DSTART;
                    n_state  = i_stat.zero_chain ? S_DFIN : S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.op = D_WALK;
                n_state  = S_WNEXT;
            end
            S_WNEXT: begin
                o_cmd.op = D_WNEXT;
                n_state  = i_stat.walk_last ? S_DFIN : S_WALK;
            end
            S_DFIN: begin
                o_cmd.op   = D_DFIN;
                o_cmd.emit = 1'b1;
                if (i_stat.out_free) n_state = S_PRD;
            end
            S_PRD: begin
                if (i_stat.pass_end) begin
                    n_state = S_PDONE;
                end else begin
                    o_cmd.op = D_PRD;
                    n_state  = S_PCHK;
                end
            end
            S_PCHK: begin
                if (!i_stat.rec_pending) begin
                    o_cmd.op = D_PSKIP;
                    n_state  = S_PRD;
                end else begin
                    o_cmd.op = D_DIVLD;
                    n_state  = S_PDIV;
                end
            end
            S_PDIV: begin
                o_cmd.op = D_DIV;
                if (i_stat.div_done) n_state = S_PFIT;
            end
            S_PFIT: begin
                if (!i_stat.fits) begin
                    o_cmd.op = D_PSKIP;
                    n_state  = S_PRD;
                end else begin
                    o_cmd.op = D_SSTART;
                    n_state  = i_stat.need_zero ? S_PEMIT : S_SRD;
                end
            end
            S_SRD: begin
                o_cmd.op = D_SRD;
                n_state  = S_SCHK;
            end
            S_SCHK: begin
                o_cmd.op = D_SCHK;
                n_state  = (i_stat.scan_free && i_stat.scan_last) ? S_PEMIT : S_SRD;
            end
            S_PEMIT: begin
                o_cmd.op   = D_PEMIT;
                o_cmd.emit = 1'b1;
                if (i_stat.out_free) n_state = S_PRD;
            end
            S_PDONE: begin
                o_cmd.op   = D_PDONE;
                o_cmd.emit = 1'b1;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        // Reformatting restarts the clearing sweep from any state.
        if (i_stat.cfg_fmt) n_state = S_CLEAR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/lba_dpath.sv =====
// ============================================================================
// Linked block allocator datapath
// Block and file memories, counters, the block-count divider and the
// result register, all driven by controller commands.
// ============================================================================
module lba_dpath #(
    parameter int NUM_BLOCKS = 64,
    parameter int MAX_FILES  = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  lba_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output lba_pkg::t_out  o_out_data,
    input  lba_pkg::t_cmd  i_cmd,
    output lba_pkg::t_stat o_stat
);
    import lba_pkg::*;

    localparam int BW  = $clog2(NUM_BLOCKS);
    localparam int CW  = $clog2(NUM_BLOCKS + 1);
    localparam int FAW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int FCW = $clog2(MAX_FILES + 1);
    localparam int NW  = (CW > 7) ? CW : 7;

    typedef struct packed {
        logic [23:0]   bytes;
        logic [1:0]    fstate;
        logic [BW-1:0] first;
        logic [BW-1:0] last;
        logic [CW-1:0] blocks;
    } t_rec;

    // Memories.
    logic          r_used_mem [NUM_BLOCKS];
    logic [BW-1:0] r_link_mem [NUM_BLOCKS];
    t_rec          r_file_mem [MAX_FILES];

    // Control registers.
    logic [15:0]    r_block_bytes;
    logic [6:0]     r_biu;
    logic [CW-1:0]  r_free;
    logic [FCW-1:0] r_file_count;
    logic [FCW-1:0] r_f;
    logic [BW-1:0]  r_h;
    logic [4:0]     r_dcnt;
    logic           r_out_valid;

    // Payload registers.
    t_in           r_item;
    t_out          r_out;
    t_rec          r_rec;
    logic          r_used_rd;
    logic [BW-1:0] r_link_rd;
    logic [BW-1:0] r_prev;
    logic [BW-1:0] r_cur;
    logic [BW-1:0] r_first;
    logic [CW-1:0] r_got;
    logic [CW-1:0] r_n;
    logic [24:0]   r_num;
    logic [15:0]   r_rem;

    logic           out_free;
    logic           go;
    logic           fire;
    logic           cfg_fmt;
    logic           full;
    logic           fid_ok;
    logic           bidx_ok;
    logic [15:0]    bb;
    logic [NW-1:0]  nb_w;
    logic [CW-1:0]  nb;
    logic [16:0]    trial;
    logic           trial_ge;
    t_out           nxt_out;

    logic           used_we, used_wd, used_re;
    logic [BW-1:0]  used_wa, used_ra;
    logic           link_we, link_re;
    logic [BW-1:0]  link_wa, link_wd, link_ra;
    logic           file_we, file_re;
    logic [FAW-1:0] file_wa, file_ra;
    t_rec           file_wd;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign go         = i_cmd.emit && out_free;
    assign fire       = (i_cmd.op == D_IDLE) && i_in_valid;
    assign o_in_stall = (i_cmd.op != D_IDLE);
    assign cfg_fmt    = i_cfg_we && (i_cfg_idx == CFG_BLOCKS_IN_USE);
    assign full       = int'(r_file_count) >= MAX_FILES;
    assign fid_ok     = (int'(r_item.file_id) < int'(r_file_count))
                     && (int'(r_item.file_id) < MAX_FILES);
    assign bidx_ok    = int'(r_item.block_index) < NUM_BLOCKS;
    assign bb         = (r_block_bytes == 16'd0) ? 16'd1 : r_block_bytes;
    assign nb_w       = (NW'(r_biu) < NW'(NUM_BLOCKS)) ? NW'(r_biu) : NW'(NUM_BLOCKS);
    assign nb         = CW'(nb_w);
    assign trial      = {r_rem, r_num[24]};
    assign trial_ge   = trial >= {1'b0, bb};

    assign o_stat.clr_done    = (r_h == BW'(NUM_BLOCKS - 1));
    assign o_stat.in_fire     = fire;
    assign o_stat.in_op       = i_in_data.opcode;
    assign o_stat.out_free    = out_free;
    assign o_stat.file_ok     = fid_ok && (r_rec.fstate == FS_ALLOC);
    assign o_stat.zero_chain  = (r_rec.blocks == '0);
    assign o_stat.walk_last   = (r_n == r_rec.blocks);
    assign o_stat.pass_end    = (r_f >= r_file_count);
    assign o_stat.rec_pending = (r_rec.fstate == FS_PENDING);
    assign o_stat.div_done    = (r_dcnt == 5'd0);
    assign o_stat.fits        = (r_num <= 25'(r_free));
    assign o_stat.need_zero   = (r_num == 25'd0);
    assign o_stat.scan_free   = !r_used_rd;
    assign o_stat.scan_last   = ((25'(r_got) + 25'd1) == r_num);
    assign o_stat.cfg_fmt     = cfg_fmt;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Memory port selection.
    always_comb begin
        used_we = 1'b0;  used_wa = r_h;  used_wd = 1'b0;
        used_re = 1'b0;  used_ra = r_h;
        link_we = 1'b0;  link_wa = r_h;  link_wd = '0;
        link_re = 1'b0;  link_ra = r_cur;
        file_we = 1'b0;  file_wa = FAW'(r_f);  file_wd = r_rec;
        file_re = 1'b0;  file_ra = FAW'(r_f);
        case (i_cmd.op)
            D_CLR: begin
                used_we = 1'b1;
                link_we = 1'b1;
            end
            D_ADD: begin
                file_we = go && !full;
                file_wa = FAW'(r_file_count);
                file_wd = '{bytes: r_item.file_bytes, fstate: FS_PENDING,
                            first: '0, last: '0, blocks: '0};
            end
            D_LRD: begin
                link_re = 1'b1;
                link_ra = BW'(r_item.block_index);
            end
            D_DRD: begin
                file_re = 1'b1;
                file_ra = FAW'(r_item.file_id);
            end
            D_WALK: begin
                used_we = 1'b1;
                used_wa = r_cur;
                link_re = 1'b1;
            end
            D_DFIN: begin
                file_we        = go;
                file_wa        = FAW'(r_item.file_id);
                file_wd.fstate = FS_DELETED;
            end
            D_PRD: begin
                file_re = 1'b1;
            end
            D_SRD: begin
                used_re = 1'b1;
            end
            D_SCHK: begin
                used_we = !r_used_rd;
                used_wd = 1'b1;
                link_we = !r_used_rd && (r_got != '0);
                link_wa = r_prev;
                link_wd = r_h;
            end
            D_PEMIT: begin
                file_we = go;
                file_wd = '{bytes: r_rec.bytes, fstate: FS_ALLOC,
                            first: r_first, last: r_prev, blocks: r_got};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (used_we) r_used_mem[used_wa] <= used_wd;
        if (used_re) r_used_rd <= r_used_mem[used_ra];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) r_link_mem[link_wa] <= link_wd;
        if (link_re) r_link_rd <= r_link_mem[link_ra];
    end

    always_ff @(posedge i_clk) begin
        if (file_we) r_file_mem[file_wa] <= file_wd;
        if (file_re) r_rec <= r_file_mem[file_ra];
    end

    // Next result.
    always_comb begin
        nxt_out           = '0;
        nxt_out.free_left = 7'(r_free);
        case (i_cmd.op)
            D_ADD: begin
                if (full) begin
                    nxt_out.status = ST_FULL;
                end else begin
                    nxt_out.status      = ST_PEND;
                    nxt_out.result_file = 5'(r_file_count);
                end
            end
            D_LEMIT: begin
                nxt_out.status     = ST_LINK;
                nxt_out.link_value = bidx_ok ? 6'(r_link_rd) : 6'd0;
                nxt_out.last       = 1'b1;
            end
            D_DBAD: begin
                nxt_out.status      = ST_IGN;
                nxt_out.result_file = r_item.file_id;
            end
            D_DFIN: begin
                nxt_out.status      = ST_DEL;
                nxt_out.result_file = r_item.file_id;
            end
            D_PEMIT: begin
                nxt_out.status       = ST_ALLOC;
                nxt_out.result_file  = 5'(r_f);
                nxt_out.start_block  = 6'(r_first);
                nxt_out.end_block    = 6'(r_prev);
                nxt_out.chain_blocks = 7'(r_got);
            end
            D_PDONE: begin
                nxt_out.status = ST_DONE;
                nxt_out.last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BB_RESET;
            r_biu         <= BIU_RESET;
            r_free        <= '0;
            r_file_count  <= '0;
            r_f           <= '0;
            r_h           <= '0;
            r_dcnt        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BLOCK_BYTES) begin
                    r_block_bytes <= i_cfg_data;
                end else begin
                    r_biu <= i_cfg_data[6:0];
                end
            end
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_fmt) begin
                r_h          <= '0;
                r_file_count <= '0;
            end else begin
                case (i_cmd.op)
                    D_CLR: begin
                        if (o_stat.clr_done) begin
                            r_h    <= '0;
                            r_free <= nb;
                        end else begin
                            r_h <= r_h + 1'b1;
                        end
                    end
                    D_ADD: begin
                        if (go) begin
                            if (!full) r_file_count <= r_file_count + 1'b1;
                            r_f <= '0;
                        end
                    end
                    D_DBAD, D_DFIN: begin
                        if (go) r_f <= '0;
                    end
                    D_WALK: begin
                        r_free <= r_free + 1'b1;
                    end
                    D_PSKIP: begin
                        r_f <= r_f + 1'b1;
                    end
                    D_DIVLD: begin
                        r_dcnt <= DIV_STEPS;
                    end
                    D_DIV: begin
                        if (r_dcnt != 5'd0) r_dcnt <= r_dcnt - 1'b1;
                    end
                    D_SSTART: begin
                        r_h <= '0;
                    end
                    D_SCHK: begin
                        r_h <= r_h + 1'b1;
                        if (!r_used_rd) r_free <= r_free - 1'b1;
                    end
                    D_PEMIT: begin
                        if (go) r_f <= r_f + 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (fire) r_item <= i_in_data;
        if (go) r_out <= nxt_out;
        case (i_cmd.op)
            D_DSTART: begin
                r_cur <= r_rec.first;
                r_n   <= '0;
            end
            D_WALK: begin
                r_n <= r_n + 1'b1;
            end
            D_WNEXT: begin
                r_cur <= r_link_rd;
            end
            D_DIVLD: begin
                r_num <= 25'(r_rec.bytes) + 25'(bb) - 25'd1;
                r_rem <= '0;
            end
            D_DIV: begin
                if (r_dcnt != 5'd0) begin
                    r_num <= {r_num[23:0], trial_ge};
                    r_rem <= trial_ge ? 16'(trial - {1'b0, bb}) : trial[15:0];
                end
            end
            D_SSTART: begin
                r_got   <= '0;
                r_first <= '0;
                r_prev  <= '0;
            end
            D_SCHK: begin
                if (!r_used_rd) begin
                    if (r_got == '0) r_first <= r_h;
                    r_prev <= r_h;
                    r_got  <= r_got + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/linked_block_allocator_unit.sv =====
// ============================================================================
// Linked block allocator
// Top level: controller and datapath of a linked disk-block allocator.
// ============================================================================
// The unit handles one operation at a time. After reset, and after every
// write of the blocks_in_use register, it sweeps the block memories and
// accepts no transfer meanwhile. A link read loads the link memory entry
// into a register and then loads the result register. An add or a delete,
// a delete after walking the freed chain block by block, is followed by the
// retry pass over every recorded file: a file that is not pending is
// skipped, a pending file goes through the 25-step block-count divider, and
// one that fits is allocated by a free-block search that restarts at block
// 0 for every file and reads the block memory one entry at a time. Each
// result is held in an output register, so the next result is prepared
// while one is waiting to be taken; a stall on the output holds the
// sequencer only when a second result is ready. Configuration is written
// through a plain write port and must only be written while idle.
module linked_block_allocator_unit #(
    parameter int NUM_BLOCKS = 64,
    parameter int MAX_FILES  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lba_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lba_pkg::t_out o_out_data
);
    import lba_pkg::*;

    // Commands from the state machine and status back from the datapath.
    t_cmd  cmd;
    t_stat stat;

    lba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // The datapath owns the memories, the divider and the result register.
    lba_dpath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .MAX_FILES  (MAX_FILES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

// ===== hw/rtl/lba_check.sv =====
// ============================================================================
// Linked block allocator port checker
// Concurrent assertions on the allocator's ports, bound to the top level.
// ============================================================================
module lba_check (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input lba_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input lba_pkg::t_out o_out_data
);
    import lba_pkg::*;

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

    // Only a link read or a pass end closes an operation.
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_LINK || o_out_data.status == ST_DONE))
        == (o_out_valid && o_out_data.last))
        else $error("last flag does not match status");

    // A valid operation keeps the input stalled while it runs.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.opcode == OP_ADD
            || i_in_data.opcode == OP_DEL || i_in_data.opcode == OP_LINK))
        |=> o_in_stall)
        else $error("input taken while an operation runs");

endmodule

bind linked_block_allocator_unit lba_check u_lba_check (.*);
